FILE: rtl/bres_pkg.sv
// Shared types and constants for the line pixel generator.
`timescale 1ns / 1ps

package bres_pkg;

  localparam int CoordBits = 9;
  localparam int RowBits   = 8;
  localparam int ShortBits = 9;
  localparam int ColorBits = 16;
  localparam int AddrBits  = 32;
  localparam int RowShift  = 10;
  localparam int ErrBits   = CoordBits + 2;

  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic                 opcode;
    logic [CoordBits-1:0] start_x;
    logic [RowBits-1:0]   start_y;
    logic [CoordBits-1:0] end_x;
    logic [RowBits-1:0]   end_y;
    logic [ColorBits-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic                      active;
    logic                      steep;
    coord_t                    major_pos;
    coord_t                    major_end;
    coord_t                    minor_pos;
    logic signed [ErrBits-1:0] error_acc;
    coord_t                    delta_major;
    coord_t                    delta_minor;
    logic                      minor_down;
    logic [ColorBits-1:0]      color;
  } line_state_t;

  typedef struct packed {
    logic                 valid_res;
    logic [ShortBits-1:0] pixel_x;
    logic [ShortBits-1:0] pixel_y;
    logic [ColorBits-1:0] pixel_color;
    logic [AddrBits-1:0]  address;
    logic                 last;
  } pixel_t;

endpackage

FILE: rtl/bresenham_line_pixel_generator.sv
// Bresenham line engine: one result per accepted item.
// Usage:
//   Input channel (in_valid_i / in_stall_o): opcode_i = start carries two
//   endpoints and a color and yields the first pixel; opcode_i = step yields
//   the next pixel of the current line. A step with no line in progress
//   yields a result with valid_res_o = 0 and all other fields zero.
//   Output channel (out_valid_o / out_stall_i): one result per input item,
//   in order, with column, row, color, byte address and a last flag.
//   Config channel (cfg_valid_i / cfg_ready_o): writes frame_base; always
//   ready. Write it only while no item is in flight.
// Timing: input register, one pass of setup/step/address logic, result
// register; the result is valid once the item has passed both registers. One
// item per cycle is sustained while the receiver does not stall, bounded by
// the combinational step update of the line state.
// Reset: asynchronous, active low; clears the pipeline valid flags, the line
// state and frame_base. When the receiver stalls, the result holds and at most
// one more item is taken into the input register before in_stall_o rises.
`timescale 1ns / 1ps

module bresenham_line_pixel_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [bres_pkg::CoordBits-1:0]    start_x_i,
  input  logic [bres_pkg::RowBits-1:0]      start_y_i,
  input  logic [bres_pkg::CoordBits-1:0]    end_x_i,
  input  logic [bres_pkg::RowBits-1:0]      end_y_i,
  input  logic [bres_pkg::ColorBits-1:0]    color_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              valid_res_o,
  output logic [bres_pkg::ShortBits-1:0]    pixel_x_o,
  output logic [bres_pkg::ShortBits-1:0]    pixel_y_o,
  output logic [bres_pkg::ColorBits-1:0]    pixel_color_o,
  output logic [bres_pkg::AddrBits-1:0]     address_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bres_pkg::AddrBits-1:0]     cfg_data_i
);

  logic                          s1_valid_q, s1_valid_d;
  bres_pkg::in_item_t            s1_item_q;
  logic                          out_valid_q, out_valid_d;
  bres_pkg::pixel_t              res_q, res_d;
  bres_pkg::line_state_t         state_q, state_d;
  logic [bres_pkg::AddrBits-1:0] frame_base_q, frame_base_d;
  logic                          out_ready, proc_en, in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign proc_en    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o  = 1'b1;
  assign frame_base_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : frame_base_q;

  bres_core u_core (
    .item_i       (s1_item_q),
    .state_i      (state_q),
    .frame_base_i (frame_base_q),
    .state_o      (state_d),
    .pixel_o      (res_d)
  );

  always_comb begin
    s1_valid_d = in_take || (s1_valid_q && !proc_en);
    out_valid_d = proc_en || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      state_q      <= '0;
      frame_base_q <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      frame_base_q <= frame_base_d;
      if (proc_en) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{opcode:  opcode_i,  start_x: start_x_i, start_y: start_y_i,
                     end_x:   end_x_i,   end_y:   end_y_i,   color:   color_i};
    end
    if (proc_en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = res_q.valid_res;
  assign pixel_x_o     = res_q.pixel_x;
  assign pixel_y_o     = res_q.pixel_y;
  assign pixel_color_o = res_q.pixel_color;
  assign address_o     = res_q.address;
  assign last_o        = res_q.last;

`ifndef SYNTH
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en && res_d.last |=> !state_q.active)
    else $error("line still active after last pixel");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en && !res_d.valid_res |-> !state_q.active && s1_item_q.opcode == bres_pkg::OpStep)
    else $error("empty result while a line is active or on start");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a full pipeline");

  a_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.active |-> state_q.major_pos <= state_q.major_end)
    else $error("major coordinate ran past the endpoint");
`endif

endmodule

FILE: rtl/bres_core.sv
// Line setup, pixel emit and error update for one item.
`timescale 1ns / 1ps

module bres_core (
  input  bres_pkg::in_item_t              item_i,
  input  bres_pkg::line_state_t           state_i,
  input  logic [bres_pkg::AddrBits-1:0]   frame_base_i,
  output bres_pkg::line_state_t           state_o,
  output bres_pkg::pixel_t                pixel_o
);

  bres_pkg::coord_t x0, y0, x1, y1, dx, dy;
  bres_pkg::coord_t a0, b0, a1, b1, a0o, b0o, a1o, b1o;
  bres_pkg::coord_t px, py;
  logic steep, swap, fin;
  bres_pkg::line_state_t setup, cur, upd;
  logic signed [bres_pkg::ErrBits:0] err_sum, err_sub;

  always_comb begin
    x0 = item_i.start_x;
    x1 = item_i.end_x;
    y0 = bres_pkg::CoordBits'(item_i.start_y);
    y1 = bres_pkg::CoordBits'(item_i.end_y);
    dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
    steep = dy > dx;
    a0 = steep ? y0 : x0;
    b0 = steep ? x0 : y0;
    a1 = steep ? y1 : x1;
    b1 = steep ? x1 : y1;
    // order endpoints so the major coordinate rises
    swap = a0 > a1;
    a0o = swap ? a1 : a0;
    b0o = swap ? b1 : b0;
    a1o = swap ? a0 : a1;
    b1o = swap ? b0 : b1;

    setup.active      = 1'b1;
    setup.steep       = steep;
    setup.major_pos   = a0o;
    setup.major_end   = a1o;
    setup.minor_pos   = b0o;
    setup.delta_major = a1o - a0o;
    setup.delta_minor = (b1o >= b0o) ? b1o - b0o : b0o - b1o;
    setup.error_acc   = bres_pkg::ErrBits'(0)
                      - $signed(bres_pkg::ErrBits'(setup.delta_major >> 1));
    setup.minor_down  = !(b0o < b1o);
    setup.color       = item_i.color;

    cur = (item_i.opcode == bres_pkg::OpStart) ? setup : state_i;

    px  = cur.steep ? cur.minor_pos : cur.major_pos;
    py  = cur.steep ? cur.major_pos : cur.minor_pos;
    fin = cur.major_pos == cur.major_end;

    err_sum = $signed({cur.error_acc[bres_pkg::ErrBits-1], cur.error_acc})
            + $signed((bres_pkg::ErrBits+1)'(cur.delta_minor));
    err_sub = err_sum - $signed((bres_pkg::ErrBits+1)'(cur.delta_major));

    upd = cur;
    if (fin) begin
      upd.active = 1'b0;
    end else begin
      upd.major_pos = cur.major_pos + 1'b1;
      if (err_sum > 0) begin
        upd.minor_pos = cur.minor_down ? cur.minor_pos - 1'b1 : cur.minor_pos + 1'b1;
        upd.error_acc = bres_pkg::ErrBits'(err_sub);
      end else begin
        upd.error_acc = bres_pkg::ErrBits'(err_sum);
      end
    end

    if (cur.active) begin
      state_o             = upd;
      pixel_o.valid_res   = 1'b1;
      pixel_o.pixel_x     = bres_pkg::ShortBits'(px);
      pixel_o.pixel_y     = bres_pkg::ShortBits'(py);
      pixel_o.pixel_color = cur.color;
      pixel_o.address     = frame_base_i
                          + (bres_pkg::AddrBits'(py) << bres_pkg::RowShift)
                          + (bres_pkg::AddrBits'(px) << 1);
      pixel_o.last        = fin;
    end else begin
      // step with no line in progress
      state_o = state_i;
      pixel_o = '0;
    end
  end

endmodule
